// File: design/bgsf_pkg.sv
`default_nettype none

package bgsf_pkg;

    // Store geometry.
    localparam int MAP_BITS  = 65536;
    localparam int WORD_W    = 64;
    localparam int MAP_WORDS = MAP_BITS / WORD_W;
    localparam int WORD_AW   = $clog2(MAP_WORDS);
    localparam int OFF_W     = $clog2(WORD_W);

    // Field widths.
    localparam int POS_W  = 16;
    localparam int LEN_W  = 14;
    localparam int BITS_W = POS_W + 1;
    localparam int OP_W   = 2;

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 2;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8192);

    // Stream widths.
    localparam int RES_W       = POS_W + 3;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;
    localparam int OUT_PAD     = TDATA_OUT_W - RES_W;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_GET  = 2'd0,
        OP_SET  = 2'd1,
        OP_NEXT = 2'd2,
        OP_PREV = 2'd3
    } t_op;

    // One result item, read_bit in the lowest bit.
    typedef struct packed {
        logic [POS_W-1:0] found_position;
        logic             found;
        logic             changed;
        logic             read_bit;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_write;
        logic scan_issue;
        logic capture;
        logic res_clr;
        logic res_rw;
        logic res_find;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic search;
        logic in_range;
        logic hit;
        logic exhausted;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: design/bgsf_ctrl.sv
`default_nettype none

module bgsf_ctrl
    import bgsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_START  = 7'b0000100,
        S_READ   = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_ENCODE = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (!i_sts.search) begin
                    n_state = S_READ;
                end else if (!i_sts.in_range) begin
                    o_cmd.res_clr = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.scan_issue = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_READ: begin
                o_cmd.res_rw = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ENCODE;
                end else if (i_sts.exhausted) begin
                    o_cmd.res_clr = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_ENCODE: begin
                o_cmd.res_find = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/bgsf_dpath.sv
`default_nettype none

module bgsf_dpath
    import bgsf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [LEN_W-1:0] i_length_bytes,
    input  wire t_op              i_operation,
    input  wire logic [POS_W-1:0] i_position,
    input  wire logic             i_bit_value,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output t_result               o_result
);

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // Lowest set bit of a word, found by halving six times.
    function automatic logic [OFF_W-1:0] low_index(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        logic [OFF_W-1:0]  idx;
        t   = v;
        idx = '0;
        for (int i = OFF_W - 1; i >= 0; i--) begin
            if ((t & ((WORD_W'(1) << (1 << i)) - WORD_W'(1))) == '0) begin
                t      = t >> (1 << i);
                idx[i] = 1'b1;
            end
        end
        return idx;
    endfunction

    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        for (int k = 0; k < WORD_W; k++) begin
            r[k] = v[WORD_W-1-k];
        end
        return r;
    endfunction

    logic [WORD_W-1:0]  mem [MAP_WORDS];

    t_op                r_op;
    logic [POS_W-1:0]   r_pos;
    logic               r_val;
    logic [WORD_AW-1:0] r_addr;
    logic [WORD_AW-1:0] r_clr_addr;
    logic               r_end_done;
    logic               r_dvld;
    logic [WORD_AW-1:0] r_didx;
    logic [WORD_W-1:0]  r_rdata;
    logic [WORD_W-1:0]  r_match;
    logic [WORD_AW-1:0] r_midx;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_vld;

    logic [BITS_W-1:0]  len_bits;
    logic [BITS_W-1:0]  bits_used;
    logic [BITS_W-1:0]  last_full;
    logic [POS_W-1:0]   last_pos;
    logic [POS_W-1:0]   start_in;
    logic               is_prev;
    logic               in_range;
    logic [WORD_AW-1:0] start_word;
    logic [WORD_AW-1:0] end_word;
    logic [WORD_W-1:0]  match;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  masked;
    logic               any_match;
    logic               bit_now;
    logic               set_we;
    logic               mem_we;
    logic [WORD_AW-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [OFF_W-1:0]   enc_idx;
    logic [OFF_W-1:0]   enc_off;

    // Bits in use, saturated at the store size.
    always_comb begin
        len_bits  = {i_length_bytes, 3'b000};
        bits_used = (len_bits > BITS_W'(MAP_BITS)) ? BITS_W'(MAP_BITS) : len_bits;
        last_full = bits_used - BITS_W'(1);
        last_pos  = last_full[POS_W-1:0];
    end

    // A downward search that starts past the end begins at the last bit in use.
    always_comb begin
        if (i_operation == OP_PREV && {1'b0, i_position} >= bits_used) begin
            start_in = last_pos;
        end else begin
            start_in = i_position;
        end
    end

    // Range checks on the held item.
    always_comb begin
        is_prev    = (r_op == OP_PREV);
        in_range   = is_prev ? (bits_used != '0) : ({1'b0, r_pos} < bits_used);
        start_word = r_pos[POS_W-1:OFF_W];
        end_word   = (r_op == OP_NEXT) ? last_pos[POS_W-1:OFF_W] : '0;
    end

    // Mask the word under test to the part of the range that it covers.
    always_comb begin
        match   = r_val ? r_rdata : ~r_rdata;
        lo_mask = ALL_ONES;
        hi_mask = ALL_ONES;
        if (is_prev) begin
            if (r_didx == start_word) begin
                hi_mask = ALL_ONES >> (~r_pos[OFF_W-1:0]);
            end
        end else begin
            if (r_didx == start_word) begin
                lo_mask = ALL_ONES << r_pos[OFF_W-1:0];
            end
            if (r_didx == end_word) begin
                hi_mask = ALL_ONES >> (~last_pos[OFF_W-1:0]);
            end
        end
        masked    = match & lo_mask & hi_mask;
        any_match = (masked != '0);
    end

    // Single-bit access and the set decision.
    always_comb begin
        bit_now = r_rdata[r_pos[OFF_W-1:0]];
        set_we  = i_cmd.res_rw && (r_op == OP_SET) && in_range && (bit_now != r_val);
    end

    // Memory write port: clearing pass or set.
    always_comb begin
        mem_we    = i_cmd.clr_write || set_we;
        mem_waddr = i_cmd.clr_write ? r_clr_addr : r_addr;
        mem_wdata = i_cmd.clr_write ? '0 :
                    (r_rdata ^ (WORD_W'(1) << r_pos[OFF_W-1:0]));
    end

    // Bitmap memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    // Item capture and scan address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_pos  <= start_in;
            r_val  <= i_bit_value;
            r_addr <= start_in[POS_W-1:OFF_W];
        end else if (i_cmd.scan_issue && !r_end_done) begin
            r_addr <= is_prev ? (r_addr - WORD_AW'(1)) : (r_addr + WORD_AW'(1));
        end
        r_didx <= r_addr;
    end

    // Scan control and clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_end_done <= 1'b0;
            r_dvld     <= 1'b0;
        end else begin
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + WORD_AW'(1);
            end
            r_dvld <= i_cmd.scan_issue && !r_end_done;
            if (i_cmd.load) begin
                r_end_done <= 1'b0;
            end else if (i_cmd.scan_issue && !r_end_done) begin
                r_end_done <= (r_addr == end_word);
            end
        end
    end

    // Hold the matching word, reversed for a downward search.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_match <= is_prev ? bit_reverse(masked) : masked;
            r_midx  <= r_didx;
        end
    end

    always_comb begin
        enc_idx = low_index(r_match);
        enc_off = is_prev ? ~enc_idx : enc_idx;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clr) begin
            r_res <= '0;
        end else if (i_cmd.res_rw) begin
            r_res.read_bit       <= (r_op == OP_GET) && in_range && bit_now;
            r_res.changed        <= (r_op == OP_SET) && in_range && (bit_now != r_val);
            r_res.found          <= 1'b0;
            r_res.found_position <= '0;
        end else if (i_cmd.res_find) begin
            r_res.read_bit       <= 1'b0;
            r_res.changed        <= 1'b0;
            r_res.found          <= 1'b1;
            r_res.found_position <= {r_midx, enc_off};
        end
    end

    // Output register; it frees the controller while a result waits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    // Status to the controller.
    always_comb begin
        o_sts.clr_last  = (r_clr_addr == '1);
        o_sts.search    = (r_op == OP_NEXT) || (r_op == OP_PREV);
        o_sts.in_range  = in_range;
        o_sts.hit       = r_dvld && any_match;
        o_sts.exhausted = r_dvld && !any_match && (r_didx == end_word);
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    // A set that writes the store reports a change.
    a_set_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_we |=> r_res.changed)
        else $error("set wrote the store without reporting a change");

    // An upward scan never tests a word outside its range.
    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dvld && r_op == OP_NEXT) |->
            (r_didx >= start_word && r_didx <= last_pos[POS_W-1:OFF_W]))
        else $error("upward scan left its word range");

    // A reported match lies within the bits in use.
    a_found_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.found) |-> ({1'b0, r_out.found_position} < bits_used))
        else $error("match reported beyond the bits in use");

    // Without a match the position reads zero.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.found) |-> (r_out.found_position == '0))
        else $error("position not zero without a match");

endmodule

`default_nettype wire

// File: design/bitmap_get_set_find_top.sv
// Channel  | Direction | Payload
// s_axis   | in        | tuser[1:0] operation; tdata position[15:0], bit_value[16]
// m_axis   | out       | tdata read_bit[0], changed[1], found[2], found_position[18:3]
// APB      | in/out    | register 0 at byte address 0: length_bytes[13:0]
//
// Get and set pass through the steps start, word read, result and output load.
// A search scans the 64-bit words of its range in turn and stops at the first word
// that holds a match; the scan reads one memory word per cycle.
// After reset the block clears all 1024 words, one per cycle, before s_axis_tready rises.
// A result waits in the output register while the next item is accepted; only the
// completion of a following item stalls behind an untaken result.
`default_nettype none

module bitmap_get_set_find_top
    import bgsf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input items.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,  // position[15:0], bit_value[16]
    input  wire logic [OP_W-1:0]        s_axis_tuser,  // operation[1:0]
    // Result items.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,  // read_bit[0], changed[1],
                                                       // found[2], found_position[18:3]
    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready
);

    logic [LEN_W-1:0] r_length_bytes;
    logic             cfg_write;
    t_cmd             cmd;
    t_sts             sts;
    t_result          result;

    // Length register; the single register decodes every address in the port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_bytes <= LEN_RESET;
        end else if (cfg_write) begin
            r_length_bytes <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = {{(APB_DW - LEN_W){1'b0}}, r_length_bytes};

    // Controller.
    bgsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath with the bitmap memory.
    bgsf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_length_bytes (r_length_bytes),
        .i_operation    (t_op'(s_axis_tuser)),
        .i_position     (s_axis_tdata[POS_W-1:0]),
        .i_bit_value    (s_axis_tdata[POS_W]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_result       (result)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, result};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bgsf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 1100;
    localparam int          REG_LENGTH     = 0;
    localparam logic [APB_AW-1:0] ADDR_LENGTH = APB_AW'(4 * REG_LENGTH);

    // Mirror of the bitmap store that predicts every result item and checks it on arrival.
    class bitmap_scoreboard;
        bit [WORD_W-1:0]  store_words [MAP_WORDS];
        logic [LEN_W-1:0] used_bytes;
        t_result          expected_q [$];
        int               mismatches;
        int               checked;

        function new();
            foreach (store_words[w]) store_words[w] = '0;
            used_bytes = LEN_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int used_bits();
            int b;
            b = int'(used_bytes) * 8;
            return (b > MAP_BITS) ? MAP_BITS : b;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit bit_at(int p);
            return store_words[p / WORD_W][p % WORD_W];
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(t_op op, logic [POS_W-1:0] pos, logic val);
            t_result         want;
            int              n;
            int              i;
            bit [WORD_W-1:0] skip;
            want = '0;
            n    = used_bits();
            // A word made only of the opposite value can be stepped over whole.
            skip = val ? '0 : '1;
            case (op)
                OP_GET: begin
                    if (int'(pos) < n) want.read_bit = bit_at(pos);
                end
                OP_SET: begin
                    if (int'(pos) < n && bit_at(pos) != val) begin
                        store_words[pos / WORD_W][pos % WORD_W] = val;
                        want.changed = 1'b1;
                    end
                end
                OP_NEXT: begin
                    i = pos;
                    while (i < n) begin
                        if (i % WORD_W == 0 && i + WORD_W <= n &&
                            store_words[i / WORD_W] == skip) begin
                            i += WORD_W;
                        end else if (bit_at(i) == val) begin
                            want.found          = 1'b1;
                            want.found_position = POS_W'(i);
                            break;
                        end else begin
                            i++;
                        end
                    end
                end
                default: begin
                    // Search down from the position, clipped to the last bit used, to bit 0.
                    if (n > 0) begin
                        i = (int'(pos) < n) ? int'(pos) : n - 1;
                        while (i >= 0) begin
                            if (i % WORD_W == WORD_W - 1 && store_words[i / WORD_W] == skip) begin
                                i -= WORD_W;
                            end else if (bit_at(i) == val) begin
                                want.found          = 1'b1;
                                want.found_position = POS_W'(i);
                                break;
                            end else begin
                                i--;
                            end
                        end
                    end
                end
            endcase
            expected_q.push_back(want);
        endfunction

        // Compare one accepted result item with the oldest prediction.
        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result bit=%0d chg=%0d found=%0d pos=%0d",
                               got.read_bit, got.changed, got.found, got.found_position));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.read_bit !== want.read_bit || got.changed !== want.changed ||
                got.found !== want.found || got.found_position !== want.found_position) begin
                flag($sformatf({"result %0d: expected bit=%0d chg=%0d found=%0d pos=%0d, ",
                                "got bit=%0d chg=%0d found=%0d pos=%0d"}, checked,
                               want.read_bit, want.changed, want.found, want.found_position,
                               got.read_bit, got.changed, got.found, got.found_position));
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;   // position[15:0], bit_value[16]
    logic [OP_W-1:0]        s_axis_tuser  = '0;   // operation[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;         // read_bit[0], changed[1], found[2],
                                                  // found_position[18:3]
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_AW-1:0]      paddr         = '0;
    logic [APB_DW-1:0]      pwdata        = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    bitmap_scoreboard mirror = new();
    bit               idle_enable = 1'b1;
    bit               hold_req    = 1'b0;
    int               requests_sent = 0;
    int               length_settings = 0;

    bitmap_get_set_find_top i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: check each accepted item, then pick tready for the next cycle.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                mirror.check_result(t_result'(m_axis_tdata[RES_W-1:0]));
            end
            if (hold_left == 0 && hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !idle_enable || ($urandom_range(99) >= 33);
            end
        end
    end

    // Watchdog: ends the run when no handshake of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles.", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one request and hold it until the block takes it.
    task automatic send_item(t_op op, logic [POS_W-1:0] pos, logic val);
        if (idle_enable && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_IN_W'({val, pos});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        mirror.note_request(op, pos, val);
        requests_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (mirror.pending() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the length register, then read it back.
    task automatic write_length(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LENGTH;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        mirror.used_bytes = LEN_W'(value);
        length_settings++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DW'(mirror.used_bytes)) begin
            mirror.flag($sformatf("length readback: expected %0d, got %0d",
                                  mirror.used_bytes, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly in-range positions, with some anywhere in the 16-bit range and at the edges.
    function automatic logic [POS_W-1:0] pick_position();
        int n;
        int hi;
        int r;
        n  = mirror.used_bits();
        hi = (n + 15 > 65535) ? 65535 : n + 15;
        r  = $urandom_range(99);
        if (r < 70) return POS_W'($urandom_range(0, hi));
        if (r < 85) return POS_W'($urandom_range(0, 65535));
        if (r < 92) return POS_W'((n > 0) ? n - 1 : 0);
        if (r < 96) return '0;
        return '1;
    endfunction

    // One setting of the length followed by a burst of random requests.
    task automatic run_phase(int len_bytes, int count);
        t_op op;
        int  r;
        write_length(len_bytes);
        repeat (count) begin
            r  = $urandom_range(99);
            op = (r < 30) ? OP_SET : (r < 50) ? OP_GET : (r < 75) ? OP_NEXT : OP_PREV;
            send_item(op, pick_position(), 1'($urandom_range(1)));
        end
        drain();
    endtask

    initial begin : stimulus
        int phase_len [10];
        int p;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full store at the reset length: edges, long searches and a search ending at bit 0.
        send_item(OP_GET,  16'd0,     1'b0);
        send_item(OP_GET,  16'hFFFF,  1'b1);
        send_item(OP_SET,  16'd0,     1'b1);
        send_item(OP_SET,  16'hFFFF,  1'b1);
        send_item(OP_SET,  16'hFFFF,  1'b1);
        send_item(OP_GET,  16'hFFFF,  1'b0);
        send_item(OP_NEXT, 16'd0,     1'b1);
        send_item(OP_NEXT, 16'd1,     1'b1);
        send_item(OP_NEXT, 16'd0,     1'b0);
        send_item(OP_PREV, 16'hFFFF,  1'b1);
        send_item(OP_PREV, 16'hFFFE,  1'b1);
        send_item(OP_PREV, 16'd0,     1'b0);
        send_item(OP_SET,  16'hFFFF,  1'b0);
        send_item(OP_NEXT, 16'hFFFF,  1'b0);
        drain();

        // Zero length: nothing reads, writes or matches.
        write_length(0);
        send_item(OP_GET,  16'd0,     1'b0);
        send_item(OP_SET,  16'd5,     1'b1);
        send_item(OP_NEXT, 16'd0,     1'b0);
        send_item(OP_PREV, 16'hFFFF,  1'b0);
        drain();

        // Length beyond the store saturates at the full map.
        write_length(16383);
        send_item(OP_GET,  16'd0,     1'b0);
        send_item(OP_PREV, 16'hFFFF,  1'b0);
        drain();

        // Short length: positions past the end, and a downward search clipped to the end.
        write_length(3);
        send_item(OP_GET,  16'd30,    1'b0);
        send_item(OP_SET,  16'd30,    1'b1);
        send_item(OP_NEXT, 16'd30,    1'b0);
        send_item(OP_PREV, 16'hFFFF,  1'b0);
        send_item(OP_NEXT, 16'd23,    1'b1);
        send_item(OP_SET,  16'd0,     1'b0);
        drain();

        // Random bursts over a spread of lengths; large maps get fewer requests.
        phase_len = '{1, 8192, $urandom_range(2, 64), 16383, 8, $urandom_range(1, 300),
                      1024, 5, $urandom_range(0, 16383), 40};
        for (p = 0; p < 10; p++) begin
            idle_enable = (p != 4);
            if (p == 5) hold_req = 1'b1;
            run_phase(phase_len[p], (phase_len[p] * 8 >= 8192) ? 40 : 65);
        end
        idle_enable = 1'b1;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests over %0d length settings; %0d results checked, %0d mismatches.",
                 requests_sent, length_settings, mirror.checked, mirror.mismatches);
        $display("Covered get, set and both searches, zero and saturated lengths, %s",
                 "positions past the end and one long output stall.");
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
